[src/foc_pkg.sv]
// Shared types, constants and helper functions of the FOC current loop.
// No dependencies; used by foc_mac and foc_current_loop_unit.
`default_nettype none

package foc_pkg;

  localparam int SINE_TABLE_DEPTH = 256;

  // Shared multiplier operand and accumulator widths.
  localparam int A_W   = 24;
  localparam int B_W   = 17;
  localparam int P_W   = A_W + B_W;
  localparam int ACC_W = 42;

  // Configuration register indexes.
  localparam logic [1:0] REG_PROP_GAIN_D  = 2'd0;
  localparam logic [1:0] REG_INTEG_GAIN_D = 2'd1;
  localparam logic [1:0] REG_PROP_GAIN_Q  = 2'd2;
  localparam logic [1:0] REG_INTEG_GAIN_Q = 2'd3;

  // Fixed transform coefficients.
  localparam logic signed [B_W-1:0] K_BETA  = 17'sd18919;
  localparam logic signed [B_W-1:0] K_HALF  = -17'sd16384;
  localparam logic signed [B_W-1:0] K_SQRT3 = 17'sd28378;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ANGLE, ST_SINCOS, ST_BETA, ST_MD1, ST_MD2, ST_MQ1, ST_MQ2,
    ST_ED, ST_IQ1, ST_VD, ST_IQ2, ST_VQ, ST_VA2, ST_VB1, ST_VB2,
    ST_OA1, ST_OA2, ST_OB, ST_OC1, ST_OC2
  } state_t;

  typedef struct packed {
    logic en;   // update the accumulator
    logic clr;  // start a new sum
    logic sub;  // subtract the product
  } mac_ctl_t;

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [15:0] r;
    if (v > 42'sd32767) r = 16'sh7fff;
    else if (v < -42'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [16:0] clamp_integ(input logic signed [ACC_W-1:0] v);
    logic signed [16:0] r;
    if (v > 42'sd32768) r = 17'sd32768;
    else if (v < -42'sd32768) r = -17'sd32768;
    else r = v[16:0];
    return r;
  endfunction

  // Quarter-wave sine entry from the Q2.30 angle x (elaboration only).
  function automatic logic [15:0] sine_entry(input logic [63:0] x);
    logic [63:0] one;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    one = 64'd1 << 30;
    x2  = (x * x) >> 30;
    t   = one;
    t   = one - (((x2 * t) >> 30) / 64'd156);
    t   = one - (((x2 * t) >> 30) / 64'd110);
    t   = one - (((x2 * t) >> 30) / 64'd72);
    t   = one - (((x2 * t) >> 30) / 64'd42);
    t   = one - (((x2 * t) >> 30) / 64'd20);
    t   = one - (((x2 * t) >> 30) / 64'd6);
    s   = (x * t) >> 30;
    r   = (s + (64'd1 << 14)) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

[src/foc_current_loop_unit.sv]
// Top level of the FOC current loop: Clarke/Park, two PI loops, inverse transforms.
// Depends on foc_pkg and foc_mac.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word: three phase currents,
//   rotor angle, d/q targets and a restart bit. Output channel
//   (out_valid/out_ready) returns one word per input: three saturated phase
//   voltages and the measured d/q currents.
//   Every product goes through one shared 24x17 multiply-accumulate unit,
//   stepped by a sequencer; in_ready stays low from input acceptance until
//   the result is registered on the output, so no new word is taken while
//   one is worked on. The shared multiplier limits the throughput.
//   The output register holds a finished word while a new input is worked
//   on; if the receiver still stalls when the next word is finished, the
//   sequencer holds in its last step until the output register frees up.
//   Gains are written through cfg_we/cfg_index/cfg_data while idle.
//   Reset (rst, synchronous) clears gains, both integrators, the sequencer
//   and out_valid. The sine table is constant logic and needs no fill.
//   restart=1 clears both integrators before that word is processed.
`default_nettype none

module foc_current_loop_unit #(
  parameter int SineDepth = foc_pkg::SINE_TABLE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] phase_cur_a,
  input  wire logic signed [15:0] phase_cur_b,
  input  wire logic signed [15:0] phase_cur_c,
  input  wire logic [15:0]        rotor_angle,
  input  wire logic signed [15:0] target_d,
  input  wire logic signed [15:0] target_q,
  input  wire logic               restart,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      volt_a,
  output logic signed [15:0]      volt_b,
  output logic signed [15:0]      volt_c,
  output logic signed [15:0]      meas_d,
  output logic signed [15:0]      meas_q
);

  localparam int PW = $clog2(4 * SineDepth);
  localparam int KW = $clog2(SineDepth + 1);
  localparam int AW = $clog2(SineDepth);
  localparam int AccW = foc_pkg::ACC_W;

  // Quarter-wave sine table, built at elaboration.
  logic [15:0] rom [SineDepth];
  for (genvar gi = 0; gi < SineDepth; gi++) begin : g_rom
    localparam logic [63:0] X = (64'd1686629713 * 64'(gi)) / SineDepth;
    assign rom[gi] = foc_pkg::sine_entry(X);
  end

  foc_pkg::state_t state, state_next;
  foc_pkg::mac_ctl_t mac_ctl;
  logic signed [foc_pkg::A_W-1:0] mac_a;
  logic signed [foc_pkg::B_W-1:0] mac_b;
  logic signed [AccW-1:0] acc;

  logic [15:0] prop_gain_d, integ_gain_d, prop_gain_q, integ_gain_q;
  logic signed [15:0] ia, ib, ic, td, tq;
  logic [15:0] ang;
  logic signed [15:0] sin_v, cos_v;
  logic signed [16:0] beta, integ_d, integ_q;
  logic signed [15:0] md, mq;
  logic signed [21:0] vd, vq;
  logic signed [23:0] va, vb;
  logic load_out;

  foc_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  // Rounded views of the accumulator.
  logic signed [AccW-1:0] acc_r12, acc_r15, acc_r16;
  assign acc_r12 = (acc + AccW'(2048)) >>> 12;
  assign acc_r15 = (acc + AccW'(16384)) >>> 15;
  assign acc_r16 = (acc + AccW'(32768)) >>> 16;

  logic signed [16:0] err_d, err_q;
  assign err_d = 17'(td) - 17'(md);
  assign err_q = 17'(tq) - 17'(mq);

  // Angle decode: acc holds angle * 4 * depth after the angle step.
  logic [PW-1:0] p;
  logic [1:0]    quad;
  logic [PW-1:0] k_full;
  logic [KW-1:0] k, k_rev, sin_idx, cos_idx;
  logic [15:0]   sin_mag, cos_mag;

  assign p = acc[16 +: PW];

  always_comb begin
    if (p >= PW'(3 * SineDepth)) begin
      quad = 2'd3;
      k_full = p - PW'(3 * SineDepth);
    end else if (p >= PW'(2 * SineDepth)) begin
      quad = 2'd2;
      k_full = p - PW'(2 * SineDepth);
    end else if (p >= PW'(SineDepth)) begin
      quad = 2'd1;
      k_full = p - PW'(SineDepth);
    end else begin
      quad = 2'd0;
      k_full = p;
    end
    k = k_full[KW-1:0];
    k_rev = KW'(SineDepth) - k;
    sin_idx = quad[0] ? k_rev : k;
    cos_idx = quad[0] ? k : k_rev;
    sin_mag = (sin_idx == KW'(SineDepth)) ? 16'd32767 : rom[sin_idx[AW-1:0]];
    cos_mag = (cos_idx == KW'(SineDepth)) ? 16'd32767 : rom[cos_idx[AW-1:0]];
  end

  assign in_ready = (state == foc_pkg::ST_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain_d <= '0;
      integ_gain_d <= '0;
      prop_gain_q <= '0;
      integ_gain_q <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        foc_pkg::REG_PROP_GAIN_D:  prop_gain_d <= cfg_data;
        foc_pkg::REG_INTEG_GAIN_D: integ_gain_d <= cfg_data;
        foc_pkg::REG_PROP_GAIN_Q:  prop_gain_q <= cfg_data;
        foc_pkg::REG_INTEG_GAIN_Q: integ_gain_q <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= foc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next step, multiplier operands and accumulate mode.
  always_comb begin
    state_next = state;
    mac_ctl = '{en: 1'b1, clr: 1'b0, sub: 1'b0};
    mac_a = '0;
    mac_b = '0;
    load_out = 1'b0;
    case (state)
      foc_pkg::ST_IDLE: begin
        mac_ctl.en = 1'b0;
        if (in_valid) state_next = foc_pkg::ST_ANGLE;
      end
      foc_pkg::ST_ANGLE: begin
        mac_ctl.clr = 1'b1;
        mac_a = foc_pkg::A_W'(ang);
        mac_b = foc_pkg::B_W'(4 * SineDepth);
        state_next = foc_pkg::ST_SINCOS;
      end
      foc_pkg::ST_SINCOS: begin
        mac_ctl.en = 1'b0;
        state_next = foc_pkg::ST_BETA;
      end
      foc_pkg::ST_BETA: begin
        mac_ctl.clr = 1'b1;
        mac_a = foc_pkg::A_W'(17'(ib) - 17'(ic));
        mac_b = foc_pkg::K_BETA;
        state_next = foc_pkg::ST_MD1;
      end
      foc_pkg::ST_MD1: begin
        mac_ctl.clr = 1'b1;
        mac_a = foc_pkg::A_W'(ia);
        mac_b = foc_pkg::B_W'(cos_v);
        state_next = foc_pkg::ST_MD2;
      end
      foc_pkg::ST_MD2: begin
        mac_a = foc_pkg::A_W'(beta);
        mac_b = foc_pkg::B_W'(sin_v);
        state_next = foc_pkg::ST_MQ1;
      end
      foc_pkg::ST_MQ1: begin
        mac_ctl.clr = 1'b1;
        mac_a = foc_pkg::A_W'(beta);
        mac_b = foc_pkg::B_W'(cos_v);
        state_next = foc_pkg::ST_MQ2;
      end
      foc_pkg::ST_MQ2: begin
        mac_ctl.sub = 1'b1;
        mac_a = foc_pkg::A_W'(ia);
        mac_b = foc_pkg::B_W'(sin_v);
        state_next = foc_pkg::ST_ED;
      end
      foc_pkg::ST_ED: begin
        mac_ctl.clr = 1'b1;
        mac_a = foc_pkg::A_W'(err_d);
        mac_b = foc_pkg::B_W'(integ_gain_d);
        state_next = foc_pkg::ST_IQ1;
      end
      foc_pkg::ST_IQ1: begin
        mac_ctl.clr = 1'b1;
        mac_a = foc_pkg::A_W'(err_d);
        mac_b = foc_pkg::B_W'(prop_gain_d);
        state_next = foc_pkg::ST_VD;
      end
      foc_pkg::ST_VD: begin
        mac_ctl.clr = 1'b1;
        mac_a = foc_pkg::A_W'(err_q);
        mac_b = foc_pkg::B_W'(integ_gain_q);
        state_next = foc_pkg::ST_IQ2;
      end
      foc_pkg::ST_IQ2: begin
        mac_ctl.clr = 1'b1;
        mac_a = foc_pkg::A_W'(err_q);
        mac_b = foc_pkg::B_W'(prop_gain_q);
        state_next = foc_pkg::ST_VQ;
      end
      foc_pkg::ST_VQ: begin
        mac_ctl.clr = 1'b1;
        mac_a = foc_pkg::A_W'(vd);
        mac_b = foc_pkg::B_W'(cos_v);
        state_next = foc_pkg::ST_VA2;
      end
      foc_pkg::ST_VA2: begin
        mac_ctl.sub = 1'b1;
        mac_a = foc_pkg::A_W'(vq);
        mac_b = foc_pkg::B_W'(sin_v);
        state_next = foc_pkg::ST_VB1;
      end
      foc_pkg::ST_VB1: begin
        mac_ctl.clr = 1'b1;
        mac_a = foc_pkg::A_W'(vd);
        mac_b = foc_pkg::B_W'(sin_v);
        state_next = foc_pkg::ST_VB2;
      end
      foc_pkg::ST_VB2: begin
        mac_a = foc_pkg::A_W'(vq);
        mac_b = foc_pkg::B_W'(cos_v);
        state_next = foc_pkg::ST_OA1;
      end
      foc_pkg::ST_OA1: begin
        mac_ctl.clr = 1'b1;
        mac_a = va;
        mac_b = foc_pkg::K_HALF;
        state_next = foc_pkg::ST_OA2;
      end
      foc_pkg::ST_OA2: begin
        mac_a = vb;
        mac_b = foc_pkg::K_SQRT3;
        state_next = foc_pkg::ST_OB;
      end
      foc_pkg::ST_OB: begin
        mac_ctl.clr = 1'b1;
        mac_a = va;
        mac_b = foc_pkg::K_HALF;
        state_next = foc_pkg::ST_OC1;
      end
      foc_pkg::ST_OC1: begin
        mac_ctl.sub = 1'b1;
        mac_a = vb;
        mac_b = foc_pkg::K_SQRT3;
        state_next = foc_pkg::ST_OC2;
      end
      foc_pkg::ST_OC2: begin
        mac_ctl.en = 1'b0;
        if (!out_valid || out_ready) begin
          load_out = 1'b1;
          state_next = foc_pkg::ST_IDLE;
        end
      end
      default: begin
        mac_ctl.en = 1'b0;
        state_next = foc_pkg::ST_IDLE;
      end
    endcase
  end

  // Integrators: cleared at reset and by restart on acceptance, updated in the IQ1 and IQ2 steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      integ_d <= '0;
      integ_q <= '0;
    end else if (in_valid && in_ready && restart) begin
      integ_d <= '0;
      integ_q <= '0;
    end else if (state == foc_pkg::ST_IQ1) begin
      integ_d <= foc_pkg::clamp_integ(acc_r16 + AccW'(integ_d));
    end else if (state == foc_pkg::ST_IQ2) begin
      integ_q <= foc_pkg::clamp_integ(acc_r16 + AccW'(integ_q));
    end
  end

  // Working registers: latch the input word on acceptance and capture each rounded result in the step after its sum.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ia <= phase_cur_a;
      ib <= phase_cur_b;
      ic <= phase_cur_c;
      ang <= rotor_angle;
      td <= target_d;
      tq <= target_q;
    end
    case (state)
      foc_pkg::ST_SINCOS: begin
        sin_v <= quad[1] ? -$signed(sin_mag) : $signed(sin_mag);
        cos_v <= (quad[1] ^ quad[0]) ? -$signed(cos_mag) : $signed(cos_mag);
      end
      foc_pkg::ST_MD1: beta <= acc_r15[16:0];
      foc_pkg::ST_MQ1: md <= foc_pkg::sat16(acc_r15);
      foc_pkg::ST_ED:  mq <= foc_pkg::sat16(acc_r15);
      foc_pkg::ST_VD:  vd <= 22'(acc_r12) + 22'(integ_d);
      foc_pkg::ST_VQ:  vq <= 22'(acc_r12) + 22'(integ_q);
      foc_pkg::ST_VB1: va <= acc_r15[23:0];
      foc_pkg::ST_OA1: vb <= acc_r15[23:0];
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  logic signed [15:0] volt_b_hold;
  always_ff @(posedge clk) begin
    if (state == foc_pkg::ST_OB) begin
      volt_b_hold <= foc_pkg::sat16(acc_r15);
    end
    if (load_out) begin
      volt_a <= foc_pkg::sat16(AccW'(va));
      volt_b <= volt_b_hold;
      volt_c <= foc_pkg::sat16(acc_r15);
      meas_d <= md;
      meas_q <= mq;
    end
  end

endmodule

`default_nettype wire

[src/foc_mac.sv]
// Shared signed multiply-accumulate unit of the FOC current loop.
// Depends on foc_pkg for widths and the control struct.
`default_nettype none

module foc_mac (
  input  wire logic                             clk,
  input  wire foc_pkg::mac_ctl_t                ctl,
  input  wire logic signed [foc_pkg::A_W-1:0]   a,
  input  wire logic signed [foc_pkg::B_W-1:0]   b,
  output logic signed [foc_pkg::ACC_W-1:0]      acc
);

  logic signed [foc_pkg::P_W-1:0]   prod;
  logic signed [foc_pkg::ACC_W-1:0] term;
  logic signed [foc_pkg::ACC_W-1:0] base;

  assign prod = a * b;
  assign term = ctl.sub ? -foc_pkg::ACC_W'(prod) : foc_pkg::ACC_W'(prod);
  assign base = ctl.clr ? '0 : acc;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= base + term;
    end
  end

endmodule

`default_nettype wire

[src/foc_chk.sv]
// Port-level checker for foc_current_loop_unit, attached by bind.
// Depends on foc_current_loop_unit port names only.
`default_nettype none

module foc_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] volt_a,
  input wire logic [15:0] meas_d
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(volt_a) && $stable(meas_d))
    else $error("output word changed while stalled");

  // The sequencer stays busy after an accept.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input accepted while busy");

  // Reset leaves the block idle with no result pending.
  a_reset: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("bad state after reset");

endmodule

bind foc_current_loop_unit foc_chk u_foc_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .volt_a    (volt_a),
  .meas_d    (meas_d)
);

`default_nettype wire
